[hw/rtl/wrpm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrpm_pkg
// Shared types, constants and the root table for the window rms / peak meter.
// ----------------------------------------------------------------------------
package wrpm_pkg;

    localparam int unsigned WRPM_WINDOW = 100;

    localparam int unsigned DB_W      = 16;
    localparam int unsigned LIN_W     = 17;
    localparam int unsigned SQ_W      = 2 * LIN_W;
    localparam int unsigned MANT_W    = 32;
    localparam int unsigned ROOT_W    = 31;
    localparam int unsigned NUM_ROOTS = 16;

    typedef logic signed [DB_W-1:0] db_t;
    typedef logic [LIN_W-1:0]       lin_t;
    typedef logic [MANT_W-1:0]      mant_t;
    typedef logic [NUM_ROOTS-1:0][ROOT_W-1:0] root_tab_t;

    // log2(10) / 20 in Q24
    localparam logic [21:0] LOG_K    = 22'd2786635;
    localparam lin_t        LIN_MAX  = 17'h1FFFF;
    localparam mant_t       MANT_ONE = 32'h4000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [63:0] wrpm_isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = v;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in q30, each by floor square root of the previous one
    function automatic root_tab_t wrpm_build_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < NUM_ROOTS; k++)
        begin
            r      = wrpm_isqrt64(r << 30);
            tab[k] = r[ROOT_W-1:0];
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/wrpm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrpm_if
// Valid / ready channels for meter samples and meter results.
// ----------------------------------------------------------------------------
interface wrpm_sample_if
    import wrpm_pkg::*;
();
    logic valid;
    logic ready;
    db_t  peak_db;
    db_t  input_peak_db;

    modport source (output valid, output peak_db, output input_peak_db, input ready);
    modport sink   (input valid, input peak_db, input input_peak_db, output ready);
endinterface

interface wrpm_result_if
    import wrpm_pkg::*;
();
    logic valid;
    logic ready;
    lin_t window_rms;
    lin_t window_max;
    lin_t input_peak_linear;

    modport source (output valid, output window_rms, output window_max,
                    output input_peak_linear, input ready);
    modport sink   (input valid, input window_rms, input window_max,
                    input input_peak_linear, output ready);
endinterface
`default_nettype wire

[hw/rtl/window_rms_peak_meter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// window_rms_peak_meter_unit
// Sliding-window rms and peak meter over linear amplitudes.
// ----------------------------------------------------------------------------
// One transaction on sample carries a peak and an input peak level in dB
// (q8.8) and yields one transaction on result: the window rms, the window
// maximum and the linear input peak, all q1.16. The peak is converted, the
// ring slot is updated, and then the window is scanned through the single
// read port of the ring memory, one entry per cycle, while the root unit and
// the input peak conversion run alongside. The result is loaded once all
// three are done and the result register is free. Samples are taken one at
// a time; a new sample is taken while the previous result still waits on
// result. The ring needs no clearing pass after reset: unwritten slots read
// as zero.
module window_rms_peak_meter_unit
    import wrpm_pkg::*;
#(
    parameter int unsigned WINDOW = WRPM_WINDOW
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    wrpm_sample_if.sink    sample,
    wrpm_result_if.source  result
);

    localparam int unsigned AW    = $clog2(WINDOW);
    localparam int unsigned SUM_W = SQ_W + $clog2(WINDOW);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CONV_PK = 3'd1;
    localparam logic [2:0] S_RD_OLD  = 3'd2;
    localparam logic [2:0] S_SUB_OLD = 3'd3;
    localparam logic [2:0] S_ADD_NEW = 3'd4;
    localparam logic [2:0] S_RUN     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    db_t              pk_code_reg;
    db_t              ipk_code_reg;
    lin_t             lin_reg;
    lin_t             in_lin_reg;
    logic [AW-1:0]    slot_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [AW-1:0]    scan_addr_reg;
    logic             scan_act_reg;
    logic             scan_pend_reg;
    logic             scan_done_reg;
    logic             ipk_done_reg;
    logic             rms_done_reg;
    logic             rms_go_reg;
    lin_t             max_reg;
    logic             out_valid_reg;
    lin_t             out_rms_reg;
    lin_t             out_max_reg;
    lin_t             out_ipk_reg;

    logic             accept;
    logic             conv_start;
    db_t              conv_code;
    lin_t             conv_lin;
    unit_stat_t       conv_stat;
    lin_t             rms_val;
    unit_stat_t       rms_stat;
    logic             ring_wr_en;
    logic [AW-1:0]    ring_rd_addr;
    lin_t             ring_rd;
    lin_t             sq_op;
    logic [SQ_W-1:0]  sq;
    logic             all_done;
    logic             out_load;

    assign accept     = sample.valid && sample.ready;
    assign conv_start = accept || (state_reg == S_ADD_NEW);
    assign conv_code  = (state_reg == S_CONV_PK) ? pk_code_reg : ipk_code_reg;

    wrpm_conv u_conv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .code  (conv_code),
        .lin   (conv_lin),
        .stat  (conv_stat)
    );

    wrpm_rms #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_rms
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rms_go_reg),
        .sum   (sum_reg),
        .rms   (rms_val),
        .stat  (rms_stat)
    );

    assign ring_wr_en   = (state_reg == S_SUB_OLD);
    assign ring_rd_addr = (state_reg == S_RD_OLD) ? slot_reg : scan_addr_reg;

    wrpm_ring #(
        .WINDOW (WINDOW)
    ) u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr_en),
        .wr_addr (slot_reg),
        .wr_data (lin_reg),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd)
    );

    // one squarer, shared by the outgoing and the incoming sample
    assign sq_op    = (state_reg == S_SUB_OLD) ? ring_rd : lin_reg;
    assign sq       = SQ_W'(sq_op) * SQ_W'(sq_op);
    assign all_done = scan_done_reg && ipk_done_reg && rms_done_reg;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CONV_PK;
            end
            S_CONV_PK:
            begin
                if (conv_stat.done)
                    state_next = S_RD_OLD;
            end
            S_RD_OLD:
            begin
                state_next = S_SUB_OLD;
            end
            S_SUB_OLD:
            begin
                state_next = S_ADD_NEW;
            end
            S_ADD_NEW:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (all_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            sum_reg       <= '0;
            scan_act_reg  <= 1'b0;
            scan_pend_reg <= 1'b0;
            scan_done_reg <= 1'b0;
            ipk_done_reg  <= 1'b0;
            rms_done_reg  <= 1'b0;
            rms_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rms_go_reg    <= 1'b0;
            scan_pend_reg <= scan_act_reg;
            case (state_reg)
                S_SUB_OLD:
                begin
                    sum_reg <= sum_reg - SUM_W'(sq);
                end
                S_ADD_NEW:
                begin
                    sum_reg       <= sum_reg + SUM_W'(sq);
                    slot_reg      <= (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    rms_go_reg    <= 1'b1;
                    scan_act_reg  <= 1'b1;
                    scan_done_reg <= 1'b0;
                    ipk_done_reg  <= 1'b0;
                    rms_done_reg  <= 1'b0;
                end
                S_RUN:
                begin
                    if (scan_act_reg && (scan_addr_reg == AW'(WINDOW - 1)))
                        scan_act_reg <= 1'b0;
                    if (scan_pend_reg && !scan_act_reg)
                        scan_done_reg <= 1'b1;
                    if (conv_stat.done)
                        ipk_done_reg <= 1'b1;
                    if (rms_stat.done)
                        rms_done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pk_code_reg  <= sample.peak_db;
            ipk_code_reg <= sample.input_peak_db;
        end
        if ((state_reg == S_CONV_PK) && conv_stat.done)
            lin_reg <= conv_lin;
        if ((state_reg == S_RUN) && conv_stat.done)
            in_lin_reg <= conv_lin;
        if (state_reg == S_ADD_NEW)
        begin
            scan_addr_reg <= '0;
            max_reg       <= '0;
        end
        else
        begin
            if (scan_act_reg)
                scan_addr_reg <= scan_addr_reg + 1'b1;
            if (scan_pend_reg && (ring_rd > max_reg))
                max_reg <= ring_rd;
        end
        if (out_load)
        begin
            out_rms_reg <= rms_val;
            out_max_reg <= max_reg;
            out_ipk_reg <= in_lin_reg;
        end
    end

    assign sample.ready             = (state_reg == S_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.window_rms        = out_rms_reg;
    assign result.window_max        = out_max_reg;
    assign result.input_peak_linear = out_ipk_reg;

    // rms of values never exceeds their maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.window_rms <= result.window_max))
        else $error("window rms above window max");

    assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.busy |-> ((state_reg == S_CONV_PK) || (state_reg == S_RUN)))
        else $error("converter busy outside its phases");

    assert property (@(posedge clk) disable iff (!rst_n)
        rms_stat.busy |-> (state_reg == S_RUN))
        else $error("mean/root unit busy outside window phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_NEW) |=>
            ({1'b0, slot_reg} < (AW+1)'(WINDOW)) && !scan_done_reg)
        else $error("ring slot out of range or stale scan flag");

endmodule
`default_nettype wire

[hw/rtl/wrpm_conv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrpm_conv
// Iterative dB (q8.8) to linear (q1.16) converter, one root product a cycle.
// ----------------------------------------------------------------------------
module wrpm_conv
    import wrpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire db_t        code,
    output lin_t            lin,
    output unit_stat_t      stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOG  = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam root_tab_t ROOTS = wrpm_build_roots();

    logic [1:0]  state_reg;
    logic [3:0]  k_reg;
    logic        done_reg;
    logic        sat_reg;
    logic        zero_reg;
    logic [4:0]  sh_reg;
    logic [15:0] f16_reg;
    mant_t       mant_reg;
    lin_t        lin_reg;

    logic signed [38:0] prod_db;
    logic [38:0]        u;
    logic [5:0]         ip;
    logic [63:0]        prod;
    logic [63:0]        rnd;
    logic [32:0]        vsum;
    logic [32:0]        vshift;
    lin_t               lin_next;

    // log2 of amplitude, offset so the integer part is never negative
    assign prod_db = $signed(code) * $signed({1'b0, LOG_K});
    assign u       = $unsigned(prod_db) + {2'b01, 37'd0};
    assign ip      = u[37:32];

    always_comb
    begin
        prod = 64'(mant_reg) * 64'(ROOTS[k_reg]);
        rnd  = prod + (64'd1 << 29);
    end

    always_comb
    begin
        vsum   = 33'(mant_reg) + (33'd1 << (sh_reg - 5'd1));
        vshift = vsum >> sh_reg;
        if (sat_reg)
            lin_next = LIN_MAX;
        else if (zero_reg)
            lin_next = '0;
        else if (vshift > 33'(LIN_MAX))
            lin_next = LIN_MAX;
        else
            lin_next = vshift[LIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_LOG;
                end
                S_LOG:
                begin
                    k_reg     <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd15)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LOG:
            begin
                sat_reg  <= (ip >= 6'd33);
                zero_reg <= (ip <= 6'd14);
                sh_reg   <= 5'(6'd46 - ip);
                f16_reg  <= u[31:16];
                mant_reg <= MANT_ONE;
            end
            S_ITER:
            begin
                if (f16_reg[~k_reg])
                    mant_reg <= rnd[61:30];
            end
            S_OUT:
            begin
                lin_reg <= lin_next;
            end
            default:
            begin
            end
        endcase
    end

    assign lin       = lin_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/wrpm_rms.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrpm_rms
// Root of the window mean: digit-by-digit square root of sum / window with no
// divide, testing root^2 * window against the sum, one root bit per cycle.
// ----------------------------------------------------------------------------
module wrpm_rms
    import wrpm_pkg::*;
#(
    parameter int unsigned WINDOW = WRPM_WINDOW,
    parameter int unsigned SUM_W  = SQ_W + $clog2(WRPM_WINDOW)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] sum,
    output lin_t                  rms,
    output unit_stat_t            stat
);

    localparam int unsigned TW = SUM_W + 2;
    localparam int unsigned CW = $clog2(LIN_W);

    localparam logic [TW-1:0] SQ_INIT = TW'(WINDOW) << (2 * (LIN_W - 1));

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SQRT = 1'b1;

    logic          state_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [TW-1:0] rem_reg;
    logic [TW-1:0] lin_term_reg;
    logic [TW-1:0] sq_term_reg;
    lin_t          root_reg;

    logic [TW-1:0] trial;
    logic          rbit;

    // rem is sum - root^2 * window, lin_term is window * root * 2^(k+1),
    // sq_term is window * 4^k for the bit k under test
    always_comb
    begin
        trial = lin_term_reg + sq_term_reg;
        rbit  = (rem_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= CW'(LIN_W - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                rem_reg      <= TW'(sum);
                lin_term_reg <= '0;
                sq_term_reg  <= SQ_INIT;
                if (start)
                    root_reg <= '0;
            end
            S_SQRT:
            begin
                sq_term_reg <= sq_term_reg >> 2;
                if (rbit)
                begin
                    rem_reg      <= rem_reg - trial;
                    lin_term_reg <= (lin_term_reg >> 1) + sq_term_reg;
                    root_reg     <= {root_reg[LIN_W-2:0], 1'b1};
                end
                else
                begin
                    lin_term_reg <= lin_term_reg >> 1;
                    root_reg     <= {root_reg[LIN_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rms       = root_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/wrpm_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrpm_ring
// Sample ring memory, one write and one registered read per cycle. Entries
// at or above the fill count read as zero.
// ----------------------------------------------------------------------------
module wrpm_ring
    import wrpm_pkg::*;
#(
    parameter int unsigned WINDOW = WRPM_WINDOW
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(WINDOW)-1:0]  wr_addr,
    input  wire lin_t                       wr_data,
    input  wire logic [$clog2(WINDOW)-1:0]  rd_addr,
    output lin_t                            rd_data
);

    localparam int unsigned FW = $clog2(WINDOW + 1);

    lin_t          mem [WINDOW];
    lin_t          rd_raw_reg;
    logic [FW-1:0] fill_reg;
    logic          hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_raw_reg <= mem[rd_addr];
    end

    // writes run in slot order from zero, so a fill count marks written slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && (fill_reg != FW'(WINDOW)))
                fill_reg <= fill_reg + 1'b1;
            hit_reg <= (FW'(rd_addr) < fill_reg);
        end
    end

    assign rd_data = hit_reg ? rd_raw_reg : '0;

endmodule
`default_nettype wire
